FILE: rtl/pph_pkg.sv
// types, codes and constants shared by the playhead phase and fade blocks
package pph_pkg;

	localparam int POS_FRAC_BITS  = 16;
	localparam int POS_INT_BITS   = 24;
	localparam int FADE_FRAC_BITS = 16;

	localparam int POS_W   = POS_INT_BITS + POS_FRAC_BITS;
	localparam int PHASE_W = POS_W + 1;
	localparam int RATE_W  = 24;
	localparam int FADE_W  = FADE_FRAC_BITS + 1;
	localparam int STEP_W  = 17;

	localparam int OP_W     = 2;
	localparam int ACTION_W = 2;
	localparam int STATE_W  = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = POS_W;

	localparam int IN_TDATA_W  = ((PHASE_W + 7) / 8) * 8;
	localparam int OUT_BITS    = ACTION_W + 1 + PHASE_W + FADE_W + STATE_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [FADE_W-1:0] FADE_FULL = FADE_W'(1) << FADE_FRAC_BITS;

	localparam logic [STATE_W-1:0] ST_INACTIVE = 2'd0;
	localparam logic [STATE_W-1:0] ST_FADEIN   = 2'd1;
	localparam logic [STATE_W-1:0] ST_ACTIVE   = 2'd2;
	localparam logic [STATE_W-1:0] ST_FADEOUT  = 2'd3;

	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_CUE     = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	localparam logic [ACTION_W-1:0] ACT_NONE     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOOP_POS = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOP_NEG = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_STOP     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_START_POS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_POS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLAY_RATE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_ENABLED = 3'd5;

	typedef struct packed {
		logic [POS_W-1:0]         start_pos;
		logic [POS_W-1:0]         end_pos;
		logic                     loop_enable;
		logic [STEP_W-1:0]        fade_step;
		logic signed [RATE_W-1:0] play_rate;
		logic                     head_enabled;
	} cfg_t;

	typedef struct packed {
		logic signed [PHASE_W-1:0] phase;
		logic [FADE_W-1:0]         fade_level;
		logic [STATE_W-1:0]        state;
	} head_t;

	typedef struct packed {
		head_t               head;
		logic                trigger;
		logic [ACTION_W-1:0] action;
	} res_t;

endpackage

FILE: rtl/pph_cfg.sv
// configuration register file written through the plain write port
module pph_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [pph_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pph_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pph_pkg::cfg_t                    cfg
);
	import pph_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_START_POS:    cfg_q.start_pos    <= cfg_data[POS_W-1:0];
				REG_END_POS:      cfg_q.end_pos      <= cfg_data[POS_W-1:0];
				REG_LOOP_ENABLE:  cfg_q.loop_enable  <= cfg_data[0];
				REG_FADE_STEP:    cfg_q.fade_step    <= cfg_data[STEP_W-1:0];
				REG_PLAY_RATE:    cfg_q.play_rate    <= $signed(cfg_data[RATE_W-1:0]);
				REG_HEAD_ENABLED: cfg_q.head_enabled <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/pph_step.sv
// next-state logic: phase step, bound check, fade ramp and state moves
module pph_step (
	input  pph_pkg::cfg_t                       cfg,
	input  pph_pkg::head_t                      cur,
	input  logic [pph_pkg::OP_W-1:0]            op,
	input  logic signed [pph_pkg::PHASE_W-1:0]  cue_position,
	output pph_pkg::res_t                       res
);
	import pph_pkg::*;

	always_comb begin
		logic signed [PHASE_W-1:0] p;
		logic                      oob;
		logic [STATE_W-1:0]        st;
		logic [FADE_W:0]           f_up;

		p    = cur.phase + PHASE_W'(cfg.play_rate);
		oob  = (p > $signed({1'b0, cfg.end_pos})) || (p < $signed({1'b0, cfg.start_pos}));
		st   = cur.state;
		f_up = {1'b0, cur.fade_level} + (FADE_W + 1)'(cfg.fade_step);

		res         = '0;
		res.head    = cur;
		res.action  = ACT_NONE;
		res.trigger = 1'b0;

		case (op)
			OP_TICK: begin
				if (cur.state != ST_INACTIVE) begin
					res.head.phase = p;
					if (cfg.head_enabled && oob) begin
						if (cfg.loop_enable) begin
							res.trigger = 1'b1;
							res.action  = (cfg.play_rate > 0) ? ACT_LOOP_POS : ACT_LOOP_NEG;
						end else begin
							st         = ST_FADEOUT;
							res.action = ACT_STOP;
						end
					end
				end
				res.head.state = st;
				if (st == ST_FADEIN) begin
					if (f_up > {1'b0, FADE_FULL}) begin
						res.head.fade_level = FADE_FULL;
						res.head.state      = ST_ACTIVE;
					end else begin
						res.head.fade_level = f_up[FADE_W-1:0];
					end
				end else if (st == ST_FADEOUT) begin
					if ((STEP_W + 1)'(cfg.fade_step) > (STEP_W + 1)'(cur.fade_level)) begin
						res.head.fade_level = '0;
						res.head.state      = ST_INACTIVE;
					end else begin
						res.head.fade_level = cur.fade_level - FADE_W'(cfg.fade_step);
					end
				end
			end
			OP_CUE: begin
				res.head.phase = cue_position;
				res.head.state = ST_FADEIN;
			end
			OP_RELEASE: begin
				res.head.state = ST_FADEOUT;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/playhead_phase_fade_fsm.sv
// top level: input register, head state, step logic and output register
// Each accepted word yields exactly one result word. A word goes from the input
// register through one pass of the step logic into the output register, so a
// result is valid on m_tdata once the output register is loaded, and a new
// word can be taken every cycle while the output is not stalled; the head
// state (phase, fade level, state code) is updated in the same cycle the
// word leaves the input register, which is what sets the one-word-per-cycle
// rate. Backpressure on the output stalls the input register in place.
// Input: s_tuser carries the operation code, s_tdata the cue position.
// Configuration writes take effect at the clock edge of the write.
module playhead_phase_fade_fsm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [pph_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pph_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pph_pkg::IN_TDATA_W-1:0]     s_tdata,   // cue_position
	input  logic [pph_pkg::OP_W-1:0]           s_tuser,   // operation
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// action, trigger, phase_out, fade_out_level, head_state_out
	output logic [pph_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import pph_pkg::*;

	cfg_t                      cfg;
	head_t                     head_q;
	res_t                      res;
	res_t                      res_q;
	logic                      valid_s1;
	logic [OP_W-1:0]           op_s1;
	logic signed [PHASE_W-1:0] cue_s1;
	logic                      m_valid_q;
	logic                      advance;

	pph_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pph_step u_step (
		.cfg          (cfg),
		.cur          (head_q),
		.op           (op_s1),
		.cue_position (cue_s1),
		.res          (res)
	);

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
			head_q    <= '{phase: '0, fade_level: '0, state: ST_INACTIVE};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_valid_q <= valid_s1;
				if (valid_s1) begin
					head_q <= res.head;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			cue_s1 <= $signed(s_tdata[PHASE_W-1:0]);
		end
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'({res_q.head.state, res_q.head.fade_level,
		res_q.head.phase, res_q.trigger, res_q.action});

endmodule
